[sv/assert_macros.svh]
// assertion macros shared by the rtl
// needs clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lds assertion failed");

// condition that must never hold outside reset
`define LDS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lds forbidden condition seen");

`endif

[sv/lds_pkg.sv]
// types and fixed widths for the lambert diffuse shader
// no dependencies
package lds_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // intermediate widths of the per channel product chain
  localparam int INT_FRAC = 12;
  localparam int A_W      = 20;
  localparam int B_LO_W   = 20;
  localparam int B_HI_W   = 16;

  // one input beat: one light seen from one hit point
  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic [15:0]        light_red;
    logic [15:0]        light_green;
    logic [15:0]        light_blue;
    logic [15:0]        intensity;
    logic [15:0]        occlusion;
    logic               last_light;
  } lds_in_t;

  // one result beat
  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } lds_out_t;

  // ambient color registers
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } lds_amb_t;

  // finished result offered by the core
  typedef struct packed {
    logic     valid;
    lds_out_t data;
  } lds_res_t;

endpackage

[sv/lds_mul.sv]
// shared signed multiplier with registered product
// depends on lds_pkg
module lds_mul import lds_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;

  // full width signed product
  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[sv/lds_regs.sv]
// apb register file holding the ambient color
// depends on lds_pkg
module lds_regs import lds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lds_amb_t    amb
);

  localparam logic [1:0] REG_AMB_RED   = 2'd0;
  localparam logic [1:0] REG_AMB_GREEN = 2'd1;
  localparam logic [1:0] REG_AMB_BLUE  = 2'd2;

  lds_amb_t   amb_r;
  lds_amb_t   amb_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // write decode, out of range indexes are dropped
  always_comb begin
    amb_nxt = amb_r;
    if (wr_en) begin
      case (reg_idx)
        REG_AMB_RED:   amb_nxt.red   = pwdata[15:0];
        REG_AMB_GREEN: amb_nxt.green = pwdata[15:0];
        REG_AMB_BLUE:  amb_nxt.blue  = pwdata[15:0];
        default:       amb_nxt = amb_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r <= '0;
    end else begin
      amb_r <= amb_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_AMB_RED:   prdata = {16'b0, amb_r.red};
      REG_AMB_GREEN: prdata = {16'b0, amb_r.green};
      REG_AMB_BLUE:  prdata = {16'b0, amb_r.blue};
      default:       prdata = '0;
    endcase
  end

  assign amb = amb_r;

endmodule

[sv/lds_core.sv]
// sequencer, accumulators and operand selection around the shared multiplier
// depends on lds_pkg and lds_mul
module lds_core import lds_pkg::*; #(
  parameter int VEC_FRAC_BITS   = 14,
  parameter int COLOR_FRAC_BITS = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  lds_in_t  in_data,
  output logic     in_stall,
  input  lds_amb_t amb,
  output lds_res_t res,
  input  logic     res_ready
);

  localparam int ONE_I = 1 << COLOR_FRAC_BITS;
  localparam int TOP_I = (ONE_I > 65535) ? 65535 : ONE_I;
  localparam logic [16:0] TOP17 = 17'(TOP_I);
  localparam logic [52:0] TOP53 = 53'(TOP_I);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_DX   = 10'b0000000010,
    ST_DY   = 10'b0000000100,
    ST_DZ   = 10'b0000001000,
    ST_COL  = 10'b0000010000,
    ST_AD   = 10'b0000100000,
    ST_BLO  = 10'b0001000000,
    ST_BHI  = 10'b0010000000,
    ST_SUM  = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } lds_state_t;

  // saturating add against the clamp ceiling
  function automatic logic [15:0] sat_add(input logic [15:0] x, input logic [15:0] y);
    logic [16:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s > TOP17) ? TOP17[15:0] : s[15:0];
  endfunction

  lds_state_t state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;
  lds_in_t    item_r;
  logic signed [MUL_A_W-1:0] dot_r, dot_nxt;
  logic [B_HI_W-1:0] bhi_r, bhi_nxt;
  logic [B_LO_W+15:0] clo_r, clo_nxt;
  logic [15:0] sum_red_r, sum_green_r, sum_blue_r;
  logic [15:0] sum_red_nxt, sum_green_nxt, sum_blue_nxt;
  logic        load_item;
  logic        acc_en;
  logic [1:0]  acc_ch;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         prod_u;
  logic [PROD_W-1:0]         b_full;
  logic [A_W-1:0]            a_val;
  logic [15:0]               colour;
  logic [52:0]               c_wide;
  logic [52:0]               c_sh;
  logic [15:0]               contrib;
  logic                      dot_pos;

  lds_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // views of the registered product
  assign prod_u  = prod;
  assign a_val   = prod_u[INT_FRAC +: A_W];
  assign b_full  = prod_u >> (2 * VEC_FRAC_BITS);
  assign dot_pos = (dot_r > 0);

  // contribution from the high and low partial products of b times occlusion
  assign c_wide  = {17'b0, clo_r} + {1'b0, prod_u[31:0], 20'b0};
  assign c_sh    = c_wide >> COLOR_FRAC_BITS;
  assign contrib = (c_sh > TOP53) ? TOP17[15:0] : c_sh[15:0];

  // light color of the current channel
  always_comb begin
    case (ch_r)
      CH_RED:   colour = item_r.light_red;
      CH_GREEN: colour = item_r.light_green;
      CH_BLUE:  colour = item_r.light_blue;
      default:  colour = '0;
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (state_r)
      ST_DX: begin
        mul_a = MUL_A_W'(item_r.normal_x);
        mul_b = MUL_B_W'(item_r.incident_x);
      end
      ST_DY: begin
        mul_a = MUL_A_W'(item_r.normal_y);
        mul_b = MUL_B_W'(item_r.incident_y);
      end
      ST_DZ: begin
        mul_a = MUL_A_W'(item_r.normal_z);
        mul_b = MUL_B_W'(item_r.incident_z);
      end
      ST_COL: begin
        mul_a = {17'b0, colour};
        mul_b = {5'b0, item_r.intensity};
      end
      ST_AD: begin
        mul_a = dot_r;
        mul_b = {1'b0, a_val};
      end
      ST_BLO: begin
        mul_a = {13'b0, b_full[B_LO_W-1:0]};
        mul_b = {5'b0, item_r.occlusion};
      end
      ST_BHI: begin
        mul_a = {17'b0, bhi_r};
        mul_b = {5'b0, item_r.occlusion};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    dot_nxt       = dot_r;
    bhi_nxt       = bhi_r;
    clo_nxt       = clo_r;
    sum_red_nxt   = sum_red_r;
    sum_green_nxt = sum_green_r;
    sum_blue_nxt  = sum_blue_r;
    load_item     = 1'b0;
    acc_en        = 1'b0;
    acc_ch        = (state_r == ST_SUM) ? CH_BLUE : ch_r - 2'd1;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          load_item = 1'b1;
          ch_nxt    = CH_RED;
          state_nxt = ST_DX;
        end
      end
      ST_DX: state_nxt = ST_DY;
      ST_DY: begin
        dot_nxt   = prod[MUL_A_W-1:0];
        state_nxt = ST_DZ;
      end
      ST_DZ: begin
        dot_nxt   = dot_r + prod[MUL_A_W-1:0];
        state_nxt = ST_COL;
      end
      ST_COL: begin
        // first pass finishes the dot product, later ones retire a channel
        if (ch_r == CH_RED) begin
          dot_nxt = dot_r + prod[MUL_A_W-1:0];
        end else begin
          acc_en = dot_pos;
        end
        state_nxt = ST_AD;
      end
      ST_AD: state_nxt = ST_BLO;
      ST_BLO: begin
        bhi_nxt   = b_full[B_LO_W +: B_HI_W];
        state_nxt = ST_BHI;
      end
      ST_BHI: begin
        clo_nxt = prod_u[B_LO_W+15:0];
        if (ch_r == CH_BLUE) begin
          state_nxt = ST_SUM;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_COL;
        end
      end
      ST_SUM: begin
        acc_en    = dot_pos;
        state_nxt = item_r.last_light ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (res_ready) begin
          sum_red_nxt   = '0;
          sum_green_nxt = '0;
          sum_blue_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // saturating accumulate of one channel
    if (acc_en) begin
      case (acc_ch)
        CH_RED:   sum_red_nxt   = sat_add(sum_red_r, contrib);
        CH_GREEN: sum_green_nxt = sat_add(sum_green_r, contrib);
        CH_BLUE:  sum_blue_nxt  = sat_add(sum_blue_r, contrib);
        default:  sum_red_nxt   = sum_red_r;
      endcase
    end
  end

  // control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= CH_RED;
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      sum_red_r   <= sum_red_nxt;
      sum_green_r <= sum_green_nxt;
      sum_blue_r  <= sum_blue_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_item) begin
      item_r <= in_data;
    end
    dot_r <= dot_nxt;
    bhi_r <= bhi_nxt;
    clo_r <= clo_nxt;
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign res.valid           = (state_r == ST_FIN);
  assign res.data.out_red    = sat_add(sum_red_r, amb.red);
  assign res.data.out_green  = sat_add(sum_green_r, amb.green);
  assign res.data.out_blue   = sat_add(sum_blue_r, amb.blue);

endmodule

[sv/lambert_diffuse_shader.sv]
// Lambertian diffuse shader. One input beat is one light seen from one hit
// point; the block takes a beat, forms the normal-light dot product and the
// per channel color x intensity x dot x occlusion chain on a single shared
// 33x21 multiplier, and accumulates each channel with saturation at 1.0.
// An input beat holds the input channel through idle, three dot product terms,
// four multiplier steps per channel and one accumulate step; a beat marked
// last_light then moves to a final state that hands its RGB result, with
// ambient added, to the output register, and waits there while that register
// is still full. The output register lets the next light start while a result
// is not yet taken. Ambient registers sit on the APB port at byte 0, 4 and 8.
// depends on lds_pkg, lds_regs, lds_core, lds_mul and assert_macros.svh
`include "assert_macros.svh"

module lambert_diffuse_shader import lds_pkg::*; #(
  parameter int VEC_FRAC_BITS   = 14,
  parameter int COLOR_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  lds_in_t     in_data,
  output logic        in_stall,
  output logic        out_valid,
  output lds_out_t    out_data,
  input  logic        out_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lds_amb_t amb;
  lds_res_t res;
  logic     res_ready;
  logic     res_load;
  logic     out_valid_r, out_valid_nxt;
  lds_out_t out_data_r;

  lds_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .amb     (amb)
  );

  lds_core #(
    .VEC_FRAC_BITS   (VEC_FRAC_BITS),
    .COLOR_FRAC_BITS (COLOR_FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .amb       (amb),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register, free when empty or its beat leaves this cycle
  assign res_ready = !out_valid_r || !out_stall;
  assign res_load  = res.valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `LDS_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)
  `LDS_NEVER(a_result_while_idle, res.valid && !in_stall)
  `LDS_ASSERT(a_out_from_core, $rose(out_valid_r) |-> $past(res.valid))

endmodule

[tb/tb_top.sv]
// self-checking testbench for lambert_diffuse_shader: directed and random light beats,
// random idling on both channels, ambient writes over apb between phases
// depends on lds_pkg and the lambert_diffuse_shader rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lds_pkg::*;

  localparam int VEC_FB = 14;
  localparam int COL_FB = 15;
  localparam logic [15:0] CLAMP_TOP = 16'h8000;

  // ambient register byte addresses
  localparam logic [3:0] AMB_RED_ADDR   = 4'd0;
  localparam logic [3:0] AMB_GREEN_ADDR = 4'd4;
  localparam logic [3:0] AMB_BLUE_ADDR  = 4'd8;
  localparam logic [3:0] SPARE_ADDR     = 4'd12;

  localparam int GAP_MAX       = 14;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_LIGHTS  = 300;
  localparam int NUM_PHASES    = 6;
  localparam int REPORT_MAX    = 10;

  // running per-channel light sums and the pixels still owed by the block
  class shade_scoreboard;
    lds_amb_t    ambient;
    logic [15:0] sum_r, sum_g, sum_b;
    lds_out_t    pixels_due[$];
    int          errors;

    function new();
      ambient = '0;
      sum_r   = '0;
      sum_g   = '0;
      sum_b   = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [31:0] data);
      case (addr)
        AMB_RED_ADDR:   ambient.red   = data[15:0];
        AMB_GREEN_ADDR: ambient.green = data[15:0];
        AMB_BLUE_ADDR:  ambient.blue  = data[15:0];
        default: ;
      endcase
    endfunction

    // add with saturation at 1.0
    function logic [15:0] sat_add16(logic [15:0] x, logic [15:0] y);
      int unsigned s;
      s = x + y;
      return (s > CLAMP_TOP) ? CLAMP_TOP : s[15:0];
    endfunction

    // color x intensity x dot x occlusion, truncating after each product
    function logic [15:0] lit_channel(logic [15:0] color, logic [15:0] inten,
                                      longint unsigned dotp, logic [15:0] occ);
      longint unsigned a, b, c;
      a = (64'(color) * 64'(inten)) >> INT_FRAC;
      b = (a * dotp) >> (2 * VEC_FB);
      c = (b * 64'(occ)) >> COL_FB;
      return (c > CLAMP_TOP) ? CLAMP_TOP : c[15:0];
    endfunction

    function void note_light(lds_in_t lt);
      longint   dotp;
      lds_out_t px;
      dotp = longint'($signed(lt.normal_x)) * longint'($signed(lt.incident_x))
           + longint'($signed(lt.normal_y)) * longint'($signed(lt.incident_y))
           + longint'($signed(lt.normal_z)) * longint'($signed(lt.incident_z));
      // back-facing or grazing lights add nothing
      if (dotp > 0) begin
        sum_r = sat_add16(sum_r, lit_channel(lt.light_red, lt.intensity, dotp, lt.occlusion));
        sum_g = sat_add16(sum_g, lit_channel(lt.light_green, lt.intensity, dotp, lt.occlusion));
        sum_b = sat_add16(sum_b, lit_channel(lt.light_blue, lt.intensity, dotp, lt.occlusion));
      end
      // last light of the hit closes the pixel
      if (lt.last_light) begin
        px.out_red   = sat_add16(sum_r, ambient.red);
        px.out_green = sat_add16(sum_g, ambient.green);
        px.out_blue  = sat_add16(sum_b, ambient.blue);
        pixels_due.push_back(px);
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
      end
    endfunction

    function void check_pixel(lds_out_t got);
      lds_out_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected pixel beat: r %0d g %0d b %0d",
                   got.out_red, got.out_green, got.out_blue);
        return;
      end
      want = pixels_due.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("pixel mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                   want.out_red, want.out_green, want.out_blue,
                   got.out_red, got.out_green, got.out_blue);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  lds_in_t     in_data;
  logic        out_valid, out_stall;
  lds_out_t    out_data;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  shade_scoreboard sb;
  bit hold_req;
  int in_calm, out_calm;

  lambert_diffuse_shader u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // idle cycles before the next beat, with occasional runs of no idling
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [15:0] pick_comp();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(0, 32768) - 16384;
      5, 6:          v = $urandom;
      7: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = -1;
          2:       v = 0;
          3:       v = 1;
          default: v = 32767;
        endcase
      end
      default:       v = $urandom_range(0, 512) - 256;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 9))
      8:       return ($urandom_range(0, 1) == 0) ? 16'h0000 : CLAMP_TOP;
      9:       return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_intensity();
    case ($urandom_range(0, 9))
      6:       return 16'd4096;
      7:       return 16'd0;
      8, 9:    return 16'($urandom);
      default: return 16'($urandom_range(0, 8192));
    endcase
  endfunction

  function automatic lds_in_t random_light(bit last);
    lds_in_t lt;
    lt.normal_x = pick_comp();
    lt.normal_y = pick_comp();
    lt.normal_z = pick_comp();
    // a third of the lights face the surface head on
    if ($urandom_range(0, 2) == 0) begin
      lt.incident_x = lt.normal_x;
      lt.incident_y = lt.normal_y;
      lt.incident_z = lt.normal_z;
    end else begin
      lt.incident_x = pick_comp();
      lt.incident_y = pick_comp();
      lt.incident_z = pick_comp();
    end
    lt.light_red   = pick_color();
    lt.light_green = pick_color();
    lt.light_blue  = pick_color();
    lt.intensity   = pick_intensity();
    lt.occlusion   = ($urandom_range(0, 4) == 0) ? CLAMP_TOP : pick_color();
    lt.last_light  = last;
    return lt;
  endfunction

  function automatic lds_in_t make_light(int nx, int ny, int nz, int ix, int iy, int iz,
                                         int cr, int cg, int cb, int inten, int occ,
                                         bit last);
    lds_in_t lt;
    lt.normal_x    = 16'(nx);
    lt.normal_y    = 16'(ny);
    lt.normal_z    = 16'(nz);
    lt.incident_x  = 16'(ix);
    lt.incident_y  = 16'(iy);
    lt.incident_z  = 16'(iz);
    lt.light_red   = 16'(cr);
    lt.light_green = 16'(cg);
    lt.light_blue  = 16'(cb);
    lt.intensity   = 16'(inten);
    lt.occlusion   = 16'(occ);
    lt.last_light  = last;
    return lt;
  endfunction

  // one input beat; valid stays high across back-to-back beats
  task automatic send_light(input lds_in_t lt);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= lt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_light(lt);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every owed pixel, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hits of mostly one to four lights, now and then a long one
  task automatic run_hits(input int n_lights);
    int sent, hit_len;
    sent = 0;
    while (sent < n_lights) begin
      hit_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int k = 0; k < hit_len; k++) send_light(random_light(k == hit_len - 1));
      sent += hit_len;
    end
  endtask

  // result side: random stall per beat, one long hold on request
  initial begin : pixel_sink
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      n = draw_wait(out_calm);
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_pixel(out_data);
    end
  end

  // give up after a long stretch with no beat moving anywhere
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    lds_amb_t amb;
    sb       = new();
    hold_req = 1'b0;
    in_calm  = 0;
    out_calm = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lights with ambient at its reset value
    // hit with no lights, sent as one dark light
    send_light(make_light(0, 0, 16384, 0, 0, 16384, 0, 0, 0, 0, 0, 1));
    // unit light straight on, full white
    send_light(make_light(16384, 0, 0, 16384, 0, 0, 32768, 32768, 32768, 4096, 32768, 1));
    // back-facing, then grazing at a zero dot
    send_light(make_light(16384, 0, 0, -16384, 0, 0, 32768, 32768, 32768, 4096, 32768, 0));
    send_light(make_light(0, 16384, 0, 16384, 0, 0, 32768, 32768, 32768, 4096, 32768, 1));
    // largest positive dot with every factor at its top code
    send_light(make_light(-32768, -32768, -32768, -32768, -32768, -32768,
                          65535, 65535, 65535, 65535, 65535, 1));
    // most negative dot
    send_light(make_light(32767, 32767, 32767, -32768, -32768, -32768,
                          65535, 65535, 65535, 65535, 65535, 0));
    // fully shadowed
    send_light(make_light(16384, 0, 0, 16384, 0, 0, 32768, 16384, 1, 4096, 0, 1));
    // three half lights, red saturates in the sum
    send_light(make_light(0, 0, 16384, 0, 0, 16384, 32768, 16384, 8192, 2048, 32768, 0));
    send_light(make_light(0, 0, 16384, 0, 0, 16384, 32768, 16384, 8192, 2048, 32768, 0));
    send_light(make_light(0, 0, 16384, 0, 0, 16384, 32768, 16384, 8192, 2048, 32768, 1));
    // tiny dot, everything truncates away
    send_light(make_light(1, 0, 0, 1, 0, 0, 1, 1, 1, 1, 1, 1));
    // mixed signs, out-of-range occlusion
    send_light(make_light(32767, -32768, 1, 32767, -32768, -1, 32768, 0, 65535, 8192, 40000, 0));
    send_light(make_light(12000, -9000, 5000, 11000, -8000, 6000,
                          20000, 30000, 10000, 12288, 24576, 1));
    // colors above 1.0 at top intensity
    send_light(make_light(0, 16384, 0, 0, 16384, 0, 40000, 50000, 60000, 65535, 32768, 1));
    // black light, bright everything else
    send_light(make_light(-16384, 0, 0, -16384, 0, 0, 0, 0, 0, 65535, 65535, 1));
    drain();

    // random phases, each under its own ambient setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       amb = '0;
        1:       amb = {CLAMP_TOP, CLAMP_TOP, CLAMP_TOP};
        2:       amb = {3{16'hffff}};
        3:       amb = {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                        16'($urandom_range(0, 32768))};
        4:       amb = {16'h0000, CLAMP_TOP, 16'hffff};
        default: amb = {16'($urandom), 16'($urandom), 16'($urandom)};
      endcase
      apb_write(AMB_RED_ADDR,   {16'($urandom), amb.red});
      apb_write(AMB_GREEN_ADDR, {16'($urandom), amb.green});
      apb_write(AMB_BLUE_ADDR,  {16'($urandom), amb.blue});
      // write to the unused slot must change nothing
      if (p == 0) apb_write(SPARE_ADDR, 32'hffff_ffff);
      // long result hold so the block backs up into its input
      if (p == 2) hold_req = 1'b1;
      run_hits(PHASE_LIGHTS);
      drain();
    end

    if (sb.errors == 0 && sb.pixels_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
